// File: hdl/rssi_beacon_battery_monitor_macros.svh
// ----------------------------------------------------------------------------
// RSSI beacon and battery monitor: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RSSI_BEACON_BATTERY_MONITOR_MACROS_SVH
`define RSSI_BEACON_BATTERY_MONITOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, reset masked
`define RBBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbbm check failed");

// next-cycle implication, reset masked
`define RBBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rbbm check failed");

`else

`define RBBM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RBBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/rbbm_pkg.sv
// ----------------------------------------------------------------------------
// RSSI beacon and battery monitor: package
// Widths, register indexes, reset values and grading thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package rbbm_pkg;

	// field widths
	localparam int RAW_W      = 10;
	localparam int PCT_W      = 7;
	localparam int TIME_W     = 32;
	localparam int HALF_W     = 16;
	localparam int BARS_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// divider: dividend holds 1023 * 100, divisor holds a raw code span
	localparam int DIV_W = 17;
	localparam int DEN_W = 10;

	// beacon interval (OFFSET - percent) * STEP ms, at most 103 * 50
	localparam int WAIT_W = 13;
	localparam int BEACON_OFFSET  = 103;
	localparam int BEACON_STEP_MS = 50;
	localparam int PCT_FULL       = 100;

	// averaging
	localparam int SAMPLES_PER_AVERAGE_DEF = 10;
	localparam int RAW_MAX = 1023;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RSSI_MIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RSSI_MAX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BEACON_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_HALF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTVL = 3'd4;

	// register reset values
	localparam logic [RAW_W-1:0]  RSSI_MIN_RST     = 10'd0;
	localparam logic [RAW_W-1:0]  RSSI_MAX_RST     = 10'd1023;
	localparam logic [HALF_W-1:0] ALARM_HALF_RST   = 16'd500;
	localparam logic [HALF_W-1:0] SAMPLE_INTVL_RST = 16'd100;

	// battery grading thresholds (10-bit codes of 5.25 V full scale)
	localparam logic [RAW_W-1:0] BATT_TOP   = 10'd828;
	localparam logic [RAW_W-1:0] BATT_BAR4  = 10'd780;
	localparam logic [RAW_W-1:0] BATT_BAR3  = 10'd741;
	localparam logic [RAW_W-1:0] BATT_BAR2  = 10'd702;
	localparam logic [RAW_W-1:0] BATT_BAR1  = 10'd663;
	localparam logic [RAW_W-1:0] BATT_ALARM = 10'd652;

endpackage

`default_nettype wire

// File: hdl/rssi_beacon_battery_monitor.sv
// ----------------------------------------------------------------------------
// RSSI beacon and battery monitor
// Takes one update (timestamp, RSSI code, battery code) at a time and returns
// one status word per update: RSSI percent, ten-sample battery average, bars,
// alarm and beacon pin levels. The RSSI percent runs through one restoring
// divider (one 11-bit compare/subtract per cycle, 17 steps), and the beacon,
// sample and alarm intervals share one 32-bit elapsed-time compare under a
// small sequencer. The ten-sample average is a reciprocal multiply in its own
// state. A result follows the divider steps and the beacon, sample, grade and
// output states, plus the average state when the update completes a battery
// average. The next update is taken in the same cycle as that result at the
// earliest. The input is stalled while the sequencer is busy. A new update
// may be taken while the previous result still waits on the output. With
// two results waiting, the second holds the block and the input stays stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rssi_beacon_battery_monitor_macros.svh"

module rssi_beacon_battery_monitor #(
	parameter int SAMPLES_PER_AVERAGE = rbbm_pkg::SAMPLES_PER_AVERAGE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration writes
	input  wire logic                             cfg_wr_en,
	input  wire logic [rbbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rbbm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// update channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [rbbm_pkg::TIME_W-1:0]      now_ms,
	input  wire logic [rbbm_pkg::RAW_W-1:0]       rssi_raw,
	input  wire logic [rbbm_pkg::RAW_W-1:0]       battery_raw,
	// status channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [rbbm_pkg::PCT_W-1:0]            rssi_percent,
	output logic [rbbm_pkg::RAW_W-1:0]            battery_average,
	output logic [rbbm_pkg::BARS_W-1:0]           battery_bars,
	output logic                                  alarm_active,
	output logic                                  low_battery_shown,
	output logic                                  alarm_out,
	output logic                                  beacon_led,
	output logic                                  buzzer_level
);

	localparam int RAW_W  = rbbm_pkg::RAW_W;
	localparam int PCT_W  = rbbm_pkg::PCT_W;
	localparam int TIME_W = rbbm_pkg::TIME_W;
	localparam int HALF_W = rbbm_pkg::HALF_W;
	localparam int BARS_W = rbbm_pkg::BARS_W;
	localparam int DIV_W  = rbbm_pkg::DIV_W;
	localparam int DEN_W  = rbbm_pkg::DEN_W;
	localparam int WAIT_W = rbbm_pkg::WAIT_W;
	localparam int DCNT_W = $clog2(DIV_W);
	localparam int CNT_W  = $clog2(SAMPLES_PER_AVERAGE + 1);
	localparam int SUM_W  = $clog2(SAMPLES_PER_AVERAGE * rbbm_pkg::RAW_MAX + 1);

	// average by reciprocal: exact for any sum up to 16 * 1023
	localparam int AVG_SHIFT = 18;
	localparam int RECIP_W   = AVG_SHIFT + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] AVG_RECIP =
		RECIP_W'((2 ** AVG_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PDIV   = 3'd1;
	localparam logic [2:0] ST_BEACON = 3'd2;
	localparam logic [2:0] ST_SAMPLE = 3'd3;
	localparam logic [2:0] ST_ADIV   = 3'd4;
	localparam logic [2:0] ST_GRADE  = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [RAW_W-1:0]  rssi_min_q;
	logic [RAW_W-1:0]  rssi_max_q;
	logic              beacon_en_q;
	logic [HALF_W-1:0] alarm_half_q;
	logic [HALF_W-1:0] sample_intvl_q;

	// latched update
	logic [TIME_W-1:0] now_q;
	logic [RAW_W-1:0]  batt_q;
	logic              pct_zero_q;

	// persistent state
	logic [TIME_W-1:0] beacon_last_q;
	logic [TIME_W-1:0] alarm_last_q;
	logic [TIME_W-1:0] sample_last_q;
	logic [CNT_W-1:0]  sample_count_q;
	logic [SUM_W-1:0]  sample_sum_q;
	logic [RAW_W-1:0]  average_q;
	logic              alarm_flag_q;
	logic              alarm_level_q;
	logic              led_q;
	logic              buzz_q;

	// per-update results
	logic [PCT_W-1:0]  pct_q;
	logic [BARS_W-1:0] bars_q;
	logic              shown_q;

	// shared divider
	logic [DIV_W-1:0]  div_num_q;
	logic [DEN_W-1:0]  div_den_q;
	logic [DEN_W-1:0]  div_rem_q;
	logic [DCNT_W-1:0] div_cnt_q;

	logic [DEN_W:0]    div_trial;
	logic [DEN_W:0]    div_diff;
	logic              div_ge;
	logic [DEN_W-1:0]  div_rem_nxt;
	logic [DIV_W-1:0]  div_num_nxt;

	// average multiply
	logic [PROD_W-1:0] avg_prod;
	logic [RAW_W-1:0]  avg_nxt;

	// output register
	logic out_valid_q;
	logic out_free;

	// update setup
	logic [RAW_W:0]    rssi_diff;
	logic [RAW_W:0]    rssi_span;
	logic [RAW_W:0]    diff_abs;
	logic [RAW_W:0]    span_abs;
	logic [DIV_W-1:0]  pct_num;
	logic              pct_zero;
	logic              in_xfer;

	// percent from quotient
	logic [PCT_W-1:0]  pct_final;

	// shared elapsed-time compare
	logic [TIME_W-1:0] last_sel;
	logic [TIME_W-1:0] limit_sel;
	logic [TIME_W-1:0] elapsed;
	logic              interval_hit;
	logic [PCT_W-1:0]  wait_base;
	logic [WAIT_W-1:0] beacon_wait;

	// sampling
	logic [CNT_W-1:0]  count_nxt;
	logic [SUM_W-1:0]  sum_nxt;

	// grading
	logic              flag_nxt;
	logic [BARS_W-1:0] bars_nxt;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// signed span and offset of the RSSI code, magnitudes for the divider
	always_comb begin
		rssi_diff = {1'b0, rssi_raw} - {1'b0, rssi_min_q};
		rssi_span = {1'b0, rssi_max_q} - {1'b0, rssi_min_q};
		diff_abs  = rssi_diff[RAW_W] ? (~rssi_diff + 1'b1) : rssi_diff;
		span_abs  = rssi_span[RAW_W] ? (~rssi_span + 1'b1) : rssi_span;
		pct_num   = DIV_W'(diff_abs[RAW_W-1:0]) * DIV_W'(rbbm_pkg::PCT_FULL);
		// zero span, or a negative quotient, clamps to zero
		pct_zero  = (rssi_span == '0) || (rssi_diff[RAW_W] != rssi_span[RAW_W]);
	end

	// one restoring division step
	always_comb begin
		div_trial   = {div_rem_q, div_num_q[DIV_W-1]};
		div_ge      = (div_trial >= {1'b0, div_den_q});
		div_diff    = div_trial - {1'b0, div_den_q};
		div_rem_nxt = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
		div_num_nxt = {div_num_q[DIV_W-2:0], div_ge};
	end

	// sample sum times the reciprocal of the sample count
	always_comb begin
		avg_prod = PROD_W'(div_num_q[SUM_W-1:0]) * PROD_W'(AVG_RECIP);
		avg_nxt  = avg_prod[AVG_SHIFT +: RAW_W];
	end

	// clamp quotient to 0..100
	always_comb begin
		if (pct_zero_q) begin
			pct_final = '0;
		end else if (div_num_nxt > DIV_W'(rbbm_pkg::PCT_FULL)) begin
			pct_final = PCT_W'(rbbm_pkg::PCT_FULL);
		end else begin
			pct_final = div_num_nxt[PCT_W-1:0];
		end
	end

	// elapsed time against the interval of the current step
	always_comb begin
		wait_base   = PCT_W'(rbbm_pkg::BEACON_OFFSET) - pct_q;
		beacon_wait = WAIT_W'(wait_base) * WAIT_W'(rbbm_pkg::BEACON_STEP_MS);
		case (state_q)
			ST_BEACON: begin
				last_sel  = beacon_last_q;
				limit_sel = TIME_W'(beacon_wait);
			end
			ST_SAMPLE: begin
				last_sel  = sample_last_q;
				limit_sel = TIME_W'(sample_intvl_q);
			end
			default: begin
				last_sel  = alarm_last_q;
				limit_sel = TIME_W'(alarm_half_q);
			end
		endcase
		elapsed      = now_q - last_sel;
		interval_hit = (elapsed >= limit_sel);
	end

	// sample accumulation
	always_comb begin
		count_nxt = sample_count_q + CNT_W'(interval_hit);
		sum_nxt   = sample_sum_q + (interval_hit ? SUM_W'(batt_q) : '0);
	end

	// bars and alarm from the average code
	always_comb begin
		flag_nxt = 1'b0;
		bars_nxt = '0;
		if (average_q > rbbm_pkg::BATT_TOP) begin
			bars_nxt = '0;
		end else if (average_q >= rbbm_pkg::BATT_BAR4) begin
			bars_nxt = BARS_W'(4);
		end else if (average_q >= rbbm_pkg::BATT_BAR3) begin
			bars_nxt = BARS_W'(3);
		end else if (average_q >= rbbm_pkg::BATT_BAR2) begin
			bars_nxt = BARS_W'(2);
		end else if (average_q >= rbbm_pkg::BATT_BAR1) begin
			bars_nxt = BARS_W'(1);
		end else if (average_q <= rbbm_pkg::BATT_ALARM) begin
			flag_nxt = 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rssi_min_q     <= rbbm_pkg::RSSI_MIN_RST;
			rssi_max_q     <= rbbm_pkg::RSSI_MAX_RST;
			beacon_en_q    <= 1'b0;
			alarm_half_q   <= rbbm_pkg::ALARM_HALF_RST;
			sample_intvl_q <= rbbm_pkg::SAMPLE_INTVL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rbbm_pkg::REG_RSSI_MIN:     rssi_min_q     <= cfg_wdata[RAW_W-1:0];
				rbbm_pkg::REG_RSSI_MAX:     rssi_max_q     <= cfg_wdata[RAW_W-1:0];
				rbbm_pkg::REG_BEACON_EN:    beacon_en_q    <= cfg_wdata[0];
				rbbm_pkg::REG_ALARM_HALF:   alarm_half_q   <= cfg_wdata[HALF_W-1:0];
				rbbm_pkg::REG_SAMPLE_INTVL: sample_intvl_q <= cfg_wdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			beacon_last_q  <= '0;
			alarm_last_q   <= '0;
			sample_last_q  <= '0;
			sample_count_q <= '0;
			sample_sum_q   <= '0;
			average_q      <= '0;
			alarm_flag_q   <= 1'b0;
			alarm_level_q  <= 1'b0;
			led_q          <= 1'b0;
			buzz_q         <= 1'b0;
			div_cnt_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						div_cnt_q <= DCNT_W'(DIV_W - 1);
						state_q   <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= ST_BEACON;
					end
				end
				ST_BEACON: begin
					// beacon sees the alarm flag of the previous update
					if (beacon_en_q) begin
						if (interval_hit) begin
							beacon_last_q <= now_q;
							led_q         <= 1'b1;
							if (!alarm_flag_q) begin
								buzz_q <= 1'b0;
							end
						end else begin
							led_q <= 1'b0;
							if (!alarm_flag_q) begin
								buzz_q <= 1'b1;
							end
						end
					end
					state_q <= ST_SAMPLE;
				end
				ST_SAMPLE: begin
					if (interval_hit) begin
						sample_last_q <= now_q;
					end
					if (count_nxt >= CNT_W'(SAMPLES_PER_AVERAGE)) begin
						sample_count_q <= '0;
						sample_sum_q   <= '0;
						state_q        <= ST_ADIV;
					end else begin
						sample_count_q <= count_nxt;
						sample_sum_q   <= sum_nxt;
						state_q        <= ST_GRADE;
					end
				end
				ST_ADIV: begin
					average_q <= avg_nxt;
					state_q   <= ST_GRADE;
				end
				ST_GRADE: begin
					alarm_flag_q <= flag_nxt;
					if (flag_nxt && interval_hit) begin
						alarm_last_q  <= now_q;
						alarm_level_q <= !alarm_level_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider datapath and per-update payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					now_q      <= now_ms;
					batt_q     <= battery_raw;
					pct_zero_q <= pct_zero;
					div_num_q  <= pct_num;
					div_den_q  <= span_abs[DEN_W-1:0];
					div_rem_q  <= '0;
				end
			end
			ST_PDIV: begin
				div_num_q <= div_num_nxt;
				div_rem_q <= div_rem_nxt;
				if (div_cnt_q == '0) begin
					pct_q <= pct_final;
				end
			end
			ST_SAMPLE: begin
				// sum held for the average multiply
				div_num_q <= DIV_W'(sum_nxt);
			end
			ST_GRADE: begin
				bars_q  <= bars_nxt;
				shown_q <= flag_nxt && alarm_level_q;
			end
			default: ;
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, loaded on the finishing transfer
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			rssi_percent      <= pct_q;
			battery_average   <= average_q;
			battery_bars      <= bars_q;
			alarm_active      <= alarm_flag_q;
			low_battery_shown <= shown_q;
			alarm_out         <= alarm_level_q;
			beacon_led        <= led_q;
			buzzer_level      <= buzz_q;
		end
	end

	// checks
	`RBBM_ASSERT_NOW(a_pct_range, clk, arst_n, out_valid, rssi_percent <= PCT_W'(rbbm_pkg::PCT_FULL))
	`RBBM_ASSERT_NOW(a_bars_no_alarm, clk, arst_n, out_valid && battery_bars != '0, !alarm_active)
	`RBBM_ASSERT_NOW(a_shown_needs_alarm, clk, arst_n, out_valid && low_battery_shown, alarm_active)
	`RBBM_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, sample_count_q < CNT_W'(SAMPLES_PER_AVERAGE))
	`RBBM_ASSERT_NEXT(a_result_lands, clk, arst_n, state_q == ST_OUT && out_free, out_valid && state_q == ST_IDLE)

endmodule

`default_nettype wire
